/* src/pulse_width_frame_decoder_unit_assert.svh */
// Assertion macros shared by the decoder RTL.
`ifndef PULSE_WIDTH_FRAME_DECODER_UNIT_ASSERT_SVH
`define PULSE_WIDTH_FRAME_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while in reset.
`define PWFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while in reset.
`define PWFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/pwfd_pkg.sv */
package pwfd_pkg;

	localparam int unsigned REG_W    = 16;
	localparam int unsigned IDX_W    = 4;
	localparam int unsigned NUM_REGS = 8;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned CNT_W    = 6;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_SPIKE      = 4'd0;
	localparam logic [IDX_W-1:0] REG_ZERO_LOW   = 4'd1;
	localparam logic [IDX_W-1:0] REG_ZERO_HIGH  = 4'd2;
	localparam logic [IDX_W-1:0] REG_ONE_LOW    = 4'd3;
	localparam logic [IDX_W-1:0] REG_ONE_HIGH   = 4'd4;
	localparam logic [IDX_W-1:0] REG_START_LOW  = 4'd5;
	localparam logic [IDX_W-1:0] REG_START_HIGH = 4'd6;
	localparam logic [IDX_W-1:0] REG_IDLE_LOW   = 4'd7;

	localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
		16'd200, 16'd1000, 16'd2999, 16'd3000, 16'd4999, 16'd5000, 16'd7000, 16'd9000
	};

	typedef enum logic [2:0] {
		SYM_ZERO,
		SYM_ONE,
		SYM_START,
		SYM_IDLE,
		SYM_UNKNOWN
	} sym_t;

	typedef enum logic {
		ST_WAIT,
		ST_FRAME
	} state_t;

	typedef struct packed {
		logic [DATA_W-1:0] frame_data;
		logic              is_long;
		logic              parity_ok;
	} result_t;

	typedef struct packed {
		logic wr;
		logic spike;
	} front_stat_t;

	typedef struct packed {
		logic take;
		logic emit;
		logic framing;
	} back_stat_t;

endpackage

/* src/pwfd_fifo.sv */
module pwfd_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int unsigned AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [AW:0]      cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + AW'(1);
			end
			if (do_rd) begin
				rptr_q <= rptr_q + AW'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + (AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* src/pwfd_front.sv */
module pwfd_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [pwfd_pkg::IDX_W-1:0] cfg_index,
	input  logic [pwfd_pkg::REG_W-1:0] cfg_data,
	input  logic                       accept,
	input  logic [pwfd_pkg::REG_W-1:0] pulse_width,
	output pwfd_pkg::sym_t             sym,
	output pwfd_pkg::front_stat_t      stat
);

	logic [pwfd_pkg::REG_W-1:0] cfg_q [pwfd_pkg::NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(pwfd_pkg::NUM_REGS); i++) begin
				cfg_q[i] <= pwfd_pkg::REG_RESET[i];
			end
		end else if (cfg_we && (cfg_index < pwfd_pkg::IDX_W'(pwfd_pkg::NUM_REGS))) begin
			cfg_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	// First matching class wins
	always_comb begin
		if (pulse_width >= cfg_q[pwfd_pkg::REG_ZERO_LOW[2:0]]
				&& pulse_width <= cfg_q[pwfd_pkg::REG_ZERO_HIGH[2:0]]) begin
			sym = pwfd_pkg::SYM_ZERO;
		end else if (pulse_width >= cfg_q[pwfd_pkg::REG_ONE_LOW[2:0]]
				&& pulse_width <= cfg_q[pwfd_pkg::REG_ONE_HIGH[2:0]]) begin
			sym = pwfd_pkg::SYM_ONE;
		end else if (pulse_width >= cfg_q[pwfd_pkg::REG_START_LOW[2:0]]
				&& pulse_width <= cfg_q[pwfd_pkg::REG_START_HIGH[2:0]]) begin
			sym = pwfd_pkg::SYM_START;
		end else if (pulse_width >= cfg_q[pwfd_pkg::REG_IDLE_LOW[2:0]]) begin
			sym = pwfd_pkg::SYM_IDLE;
		end else begin
			sym = pwfd_pkg::SYM_UNKNOWN;
		end
	end

	// Drop spikes before they reach the symbol queue
	assign stat.spike = (pulse_width < cfg_q[pwfd_pkg::REG_SPIKE[2:0]]);
	assign stat.wr    = accept && !stat.spike;

endmodule

/* src/pwfd_back.sv */
module pwfd_back #(
	parameter int unsigned SHORT_BITS = 16,
	parameter int unsigned LONG_BITS  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sym_empty,
	input  pwfd_pkg::sym_t        sym,
	input  logic                  out_full,
	output pwfd_pkg::result_t     result,
	output pwfd_pkg::back_stat_t  stat
);

	localparam int unsigned CW = pwfd_pkg::CNT_W;
	localparam int unsigned DW = pwfd_pkg::DATA_W;

	pwfd_pkg::state_t state_q;
	pwfd_pkg::state_t state_d;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    cnt_d;
	logic [DW-1:0]    data_q;
	logic [DW-1:0]    data_d;
	logic             par_q;
	logic             par_d;
	logic             long_q;
	logic             long_d;
	logic [CW-1:0]    nbits;
	logic             take;
	logic             is_bit;
	logic             bit_val;
	logic             emit;

	assign take    = !sym_empty && !out_full;
	assign is_bit  = (sym == pwfd_pkg::SYM_ZERO) || (sym == pwfd_pkg::SYM_ONE);
	assign bit_val = (sym == pwfd_pkg::SYM_ONE);
	assign nbits   = long_q ? CW'(LONG_BITS) : CW'(SHORT_BITS);

	always_comb begin
		state_d = state_q;
		if (take) begin
			if (sym == pwfd_pkg::SYM_START) begin
				state_d = pwfd_pkg::ST_FRAME;
			end else if (sym == pwfd_pkg::SYM_IDLE) begin
				state_d = pwfd_pkg::ST_WAIT;
			end else if (state_q == pwfd_pkg::ST_FRAME) begin
				if (!is_bit || (cnt_q != '0 && cnt_q > nbits)) begin
					state_d = pwfd_pkg::ST_WAIT;
				end
			end
		end
	end

	always_comb begin
		cnt_d  = cnt_q;
		data_d = data_q;
		par_d  = par_q;
		long_d = long_q;
		emit   = 1'b0;
		if (take) begin
			if (sym == pwfd_pkg::SYM_START || sym == pwfd_pkg::SYM_IDLE
					|| (state_q == pwfd_pkg::ST_FRAME && !is_bit)) begin
				cnt_d  = '0;
				data_d = '0;
				par_d  = 1'b1;
				long_d = 1'b0;
			end else if (state_q == pwfd_pkg::ST_FRAME) begin
				if (cnt_q == '0) begin
					long_d = bit_val;
					cnt_d  = CW'(1);
				end else if (cnt_q <= nbits) begin
					data_d = {data_q[DW-2:0], bit_val};
					par_d  = par_q ^ bit_val;
					cnt_d  = cnt_q + CW'(1);
				end else begin
					// Parity position emits; anything beyond just resets
					emit   = (cnt_q == nbits + CW'(1));
					cnt_d  = '0;
					data_d = '0;
					par_d  = 1'b1;
					long_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pwfd_pkg::ST_WAIT;
			cnt_q   <= '0;
			data_q  <= '0;
			par_q   <= 1'b1;
			long_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			data_q  <= data_d;
			par_q   <= par_d;
			long_q  <= long_d;
		end
	end

	assign result.frame_data = data_q;
	assign result.is_long    = long_q;
	assign result.parity_ok  = (bit_val == par_q);

	assign stat.take    = take;
	assign stat.emit    = emit;
	assign stat.framing = (state_q == pwfd_pkg::ST_FRAME);

endmodule

/* src/pulse_width_frame_decoder_unit.sv */
// The result queue takes a result as the item with its parity bit leaves the symbol queue.
// Throughput: one item per cycle unless full; back end: one per cycle while results have room.
// Symbol queue (4 deep) and result queue (2 deep) let each side stall on its own.
// Reset (arst_n low, asynchronous): queues empty, frame state cleared, thresholds to defaults.
`include "pulse_width_frame_decoder_unit_assert.svh"

module pulse_width_frame_decoder_unit #(
	parameter int unsigned SHORT_BITS = 16,
	parameter int unsigned LONG_BITS  = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input side
	input  logic                        push,
	output logic                        full,
	input  logic [pwfd_pkg::REG_W-1:0]  pulse_width,
	// result side
	output logic                        empty,
	input  logic                        pop,
	output logic [pwfd_pkg::DATA_W-1:0] frame_data,
	output logic                        is_long,
	output logic                        parity_ok,
	// configuration writes
	input  logic                        cfg_we,
	input  logic [pwfd_pkg::IDX_W-1:0]  cfg_index,
	input  logic [pwfd_pkg::REG_W-1:0]  cfg_data
);

	localparam int unsigned SYM_DEPTH = 4;
	localparam int unsigned OUT_DEPTH = 2;
	localparam int unsigned SYM_W     = $bits(pwfd_pkg::sym_t);
	localparam int unsigned RES_W     = $bits(pwfd_pkg::result_t);

	pwfd_pkg::sym_t        front_sym;
	pwfd_pkg::front_stat_t front_stat;
	logic [SYM_W-1:0]      sym_raw;
	pwfd_pkg::sym_t        back_sym;
	logic                  sym_empty;
	pwfd_pkg::back_stat_t  back_stat;
	pwfd_pkg::result_t     back_res;
	pwfd_pkg::result_t     out_res;
	logic [RES_W-1:0]      out_raw;
	logic                  out_full;
	logic                  accept;

	// An item is taken whenever the symbol queue has room
	assign accept = push && !full;

	// Front: hold thresholds, classify each width, drop spikes
	pwfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.pulse_width(pulse_width),
		.sym        (front_sym),
		.stat       (front_stat)
	);

	// Symbol queue between classifier and frame machine
	pwfd_fifo #(
		.WIDTH(SYM_W),
		.DEPTH(SYM_DEPTH)
	) u_sym_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (front_stat.wr),
		.wdata (front_sym),
		.rd    (back_stat.take),
		.rdata (sym_raw),
		.full  (full),
		.empty (sym_empty)
	);

	assign back_sym = pwfd_pkg::sym_t'(sym_raw);

	// Back: advance the frame machine, one symbol a cycle while results have room
	pwfd_back #(
		.SHORT_BITS(SHORT_BITS),
		.LONG_BITS (LONG_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.sym_empty(sym_empty),
		.sym      (back_sym),
		.out_full (out_full),
		.result   (back_res),
		.stat     (back_stat)
	);

	// Result queue toward the consumer
	pwfd_fifo #(
		.WIDTH(RES_W),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (back_stat.emit),
		.wdata (back_res),
		.rd    (pop),
		.rdata (out_raw),
		.full  (out_full),
		.empty (empty)
	);

	assign out_res    = pwfd_pkg::result_t'(out_raw);
	assign frame_data = out_res.frame_data;
	assign is_long    = out_res.is_long;
	assign parity_ok  = out_res.parity_ok;

	// A spike never reaches the symbol queue
	`PWFD_ASSERT_NOW(a_spike_dropped, accept && front_stat.spike, !front_stat.wr, "spike was queued")
	// A result is produced only inside a frame and only into a result queue with room
	`PWFD_ASSERT_NOW(a_emit_framed, back_stat.emit, back_stat.framing && !out_full, "bad emit")
	// After a result the machine waits for the next start
	`PWFD_ASSERT_NEXT(a_emit_closes, back_stat.emit, !back_stat.framing, "frame left open")

endmodule
